// ===== hw/rtl/iag_pkg.sv =====
`default_nettype none

package iag_pkg;

    localparam int MAX_CHANNELS_DEF = 1024;
    localparam int MAX_DIM_DEF      = 1024;
    localparam int MAX_KERNEL_DEF   = 15;
    localparam int ADDR_WIDTH_DEF   = 32;

    localparam int CFG_COUNT  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int SHAPE_W    = 4;
    localparam int COL_IDX_W  = 38;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT  = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_IMAGE_WIDTH    = 3'd2,
        REG_KERNEL_SHAPE   = 3'd3,
        REG_STRIDE_SHAPE   = 3'd4,
        REG_PAD_SHAPE      = 3'd5,
        REG_DILATION_SHAPE = 3'd6
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] CHANNEL_COUNT_RST = 11'd1;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST  = 11'd1;
    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST   = 11'd1;
    localparam logic [7:0]            KERNEL_SHAPE_RST   = 8'h33;
    localparam logic [7:0]            STRIDE_SHAPE_RST   = 8'h11;
    localparam logic [7:0]            PAD_SHAPE_RST      = 8'h00;
    localparam logic [7:0]            DILATION_SHAPE_RST = 8'h11;

    typedef struct packed {
        logic prep;
        logic div_start;
        logic div_col;
        logic load_rows;
        logic load_cols;
        logic run;
    } iag_cmd_t;

    typedef struct packed {
        logic cfg_hit;
        logic div_done;
    } iag_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iag_divider.sv =====
`default_nettype none

module iag_divider #(
    parameter int NUM_W = 17
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [NUM_W-1:0]                 dividend,
    input  wire  [iag_pkg::SHAPE_W-1:0]      divisor,
    output logic [NUM_W-1:0]                 quotient,
    output logic                             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int SW    = iag_pkg::SHAPE_W;

    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [SW-1:0]    rem_reg;
    logic [SW-1:0]    rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SW:0]      trial;
    logic [SW:0]      diff;
    logic             ge;
    logic             final_step;

    // one quotient bit per cycle, restoring
    assign trial      = {rem_reg, quo_reg[NUM_W-1]};
    assign ge         = trial >= {1'b0, divisor};
    assign diff       = trial - {1'b0, divisor};
    assign rem_next   = ge ? diff[SW-1:0] : trial[SW-1:0];
    assign quo_next   = {quo_reg[NUM_W-2:0], ge};
    assign final_step = busy_reg && (cnt_reg == CNT_W'(NUM_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= final_step;
            if (final_step)
            begin
                busy_reg <= 1'b0;
            end
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/iag_ctrl.sv =====
`default_nettype none

module iag_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire  iag_pkg::iag_status_t status,
    output iag_pkg::iag_cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_PREP     = 6'b000001,
        ST_ROW_GO   = 6'b000010,
        ST_ROW_WAIT = 6'b000100,
        ST_COL_GO   = 6'b001000,
        ST_COL_WAIT = 6'b010000,
        ST_RUN      = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        if (status.cfg_hit)
        begin
            state_next = ST_PREP;
        end
        else
        begin
            unique case (state_reg)
                ST_PREP:     state_next = ST_ROW_GO;
                ST_ROW_GO:   state_next = ST_ROW_WAIT;
                ST_ROW_WAIT: state_next = status.div_done ? ST_COL_GO : ST_ROW_WAIT;
                ST_COL_GO:   state_next = ST_COL_WAIT;
                ST_COL_WAIT: state_next = status.div_done ? ST_RUN : ST_COL_WAIT;
                ST_RUN:      state_next = ST_RUN;
                default:     state_next = ST_PREP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PREP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.prep      = state_reg == ST_PREP;
        cmd.div_start = (state_reg == ST_ROW_GO) || (state_reg == ST_COL_GO);
        cmd.div_col   = (state_reg == ST_COL_GO) || (state_reg == ST_COL_WAIT);
        cmd.load_rows = (state_reg == ST_ROW_WAIT) && status.div_done;
        cmd.load_cols = (state_reg == ST_COL_WAIT) && status.div_done;
        cmd.run       = state_reg == ST_RUN;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/iag_datapath.sv =====
`default_nettype none

module iag_datapath #(
    parameter int MAX_CHANNELS = iag_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_DIM      = iag_pkg::MAX_DIM_DEF,
    parameter int MAX_KERNEL   = iag_pkg::MAX_KERNEL_DEF,
    parameter int ADDR_WIDTH   = iag_pkg::ADDR_WIDTH_DEF,
    localparam int IN_DATA_W   = ((ADDR_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((ADDR_WIDTH + iag_pkg::COL_IDX_W + 7) / 8) * 8
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [iag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [iag_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [IN_DATA_W-1:0]               s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [OUT_DATA_W-1:0]              m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    input  wire  iag_pkg::iag_cmd_t            cmd,
    output iag_pkg::iag_status_t               status
);

    localparam int CFG_LIM = (1 << iag_pkg::CFG_DATA_W) - 1;
    localparam int CH_LIM  = (MAX_CHANNELS < CFG_LIM) ? MAX_CHANNELS : CFG_LIM;
    localparam int DIM_LIM = (MAX_DIM < CFG_LIM) ? MAX_DIM : CFG_LIM;
    localparam int CH_W    = $clog2(CH_LIM + 1);
    localparam int DIM_W   = $clog2(DIM_LIM + 1);
    localparam int KW      = $clog2(MAX_KERNEL + 1);
    localparam int SW      = iag_pkg::SHAPE_W;
    localparam int NUM_W   = DIM_W + 6;
    localparam int NUMS_W  = NUM_W + 1;
    localparam int COORD_W = (DIM_W + 3 > 9) ? DIM_W + 3 : 9;
    localparam int TOFF_W  = 2 * SW;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int CI_W    = iag_pkg::COL_IDX_W;
    localparam int CD_W    = iag_pkg::CFG_DATA_W;

    // configuration registers
    logic [CD_W-1:0] chan_cfg_reg;
    logic [CD_W-1:0] height_cfg_reg;
    logic [CD_W-1:0] width_cfg_reg;
    logic [7:0]      kernel_cfg_reg;
    logic [7:0]      stride_cfg_reg;
    logic [7:0]      pad_cfg_reg;
    logic [7:0]      dil_cfg_reg;
    logic            cfg_hit;

    assign cfg_hit = cfg_we && (cfg_index < iag_pkg::CFG_IDX_W'(iag_pkg::CFG_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg   <= iag_pkg::CHANNEL_COUNT_RST;
            height_cfg_reg <= iag_pkg::IMAGE_HEIGHT_RST;
            width_cfg_reg  <= iag_pkg::IMAGE_WIDTH_RST;
            kernel_cfg_reg <= iag_pkg::KERNEL_SHAPE_RST;
            stride_cfg_reg <= iag_pkg::STRIDE_SHAPE_RST;
            pad_cfg_reg    <= iag_pkg::PAD_SHAPE_RST;
            dil_cfg_reg    <= iag_pkg::DILATION_SHAPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (iag_pkg::cfg_reg_t'(cfg_index))
                iag_pkg::REG_CHANNEL_COUNT:  chan_cfg_reg   <= cfg_data;
                iag_pkg::REG_IMAGE_HEIGHT:   height_cfg_reg <= cfg_data;
                iag_pkg::REG_IMAGE_WIDTH:    width_cfg_reg  <= cfg_data;
                iag_pkg::REG_KERNEL_SHAPE:   kernel_cfg_reg <= cfg_data[7:0];
                iag_pkg::REG_STRIDE_SHAPE:   stride_cfg_reg <= cfg_data[7:0];
                iag_pkg::REG_PAD_SHAPE:      pad_cfg_reg    <= cfg_data[7:0];
                iag_pkg::REG_DILATION_SHAPE: dil_cfg_reg    <= cfg_data[7:0];
                default:                     ;
            endcase
        end
    end

    logic [SW-1:0] kh_raw, kw_raw, sv, sh, pv, ph, dv, dh;

    assign kh_raw = kernel_cfg_reg[7:4];
    assign kw_raw = kernel_cfg_reg[3:0];
    assign sv     = stride_cfg_reg[7:4];
    assign sh     = stride_cfg_reg[3:0];
    assign pv     = pad_cfg_reg[7:4];
    assign ph     = pad_cfg_reg[3:0];
    assign dv     = dil_cfg_reg[7:4];
    assign dh     = dil_cfg_reg[3:0];

    // clamped geometry and size numerators
    logic [CH_W-1:0]   eff_c_c;
    logic [DIM_W-1:0]  eff_h_c, eff_w_c;
    logic [KW-1:0]     kh_c, kw_c;
    logic [TOFF_W-1:0] dk_row, dk_col;
    logic [NUMS_W-1:0] num_row, num_col;
    logic              zero_row, zero_col;
    logic [PROD_W-1:0] hw_c;

    assign eff_c_c = (chan_cfg_reg > CD_W'(CH_LIM)) ? CH_W'(CH_LIM) : CH_W'(chan_cfg_reg);
    assign eff_h_c = (height_cfg_reg > CD_W'(DIM_LIM)) ? DIM_W'(DIM_LIM) : DIM_W'(height_cfg_reg);
    assign eff_w_c = (width_cfg_reg > CD_W'(DIM_LIM)) ? DIM_W'(DIM_LIM) : DIM_W'(width_cfg_reg);
    assign kh_c    = (kh_raw > SW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(kh_raw);
    assign kw_c    = (kw_raw > SW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(kw_raw);
    assign dk_row  = TOFF_W'(dv) * TOFF_W'(SW'(kh_c) - SW'(1));
    assign dk_col  = TOFF_W'(dh) * TOFF_W'(SW'(kw_c) - SW'(1));
    assign num_row = NUMS_W'(eff_h_c) + NUMS_W'({pv, 1'b0}) - NUMS_W'(dk_row) - NUMS_W'(1);
    assign num_col = NUMS_W'(eff_w_c) + NUMS_W'({ph, 1'b0}) - NUMS_W'(dk_col) - NUMS_W'(1);
    assign zero_row = (kh_c == '0) || (sv == '0) || num_row[NUMS_W-1];
    assign zero_col = (kw_c == '0) || (sh == '0) || num_col[NUMS_W-1];
    assign hw_c     = PROD_W'(eff_h_c) * PROD_W'(eff_w_c);

    logic [CH_W-1:0]       eff_c_reg;
    logic [DIM_W-1:0]      eff_h_reg, eff_w_reg;
    logic [KW-1:0]         kh_reg, kw_reg;
    logic [NUM_W-1:0]      num_row_reg, num_col_reg;
    logic [ADDR_WIDTH-1:0] hw_reg;
    logic                  empty_reg;
    logic [NUM_W-1:0]      rows_total_reg, cols_total_reg;
    logic [NUM_W-1:0]      div_quo;
    logic                  div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= 1'b1;
        end
        else if (cmd.prep)
        begin
            empty_reg <= zero_row || zero_col || (eff_c_c == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            eff_c_reg   <= eff_c_c;
            eff_h_reg   <= eff_h_c;
            eff_w_reg   <= eff_w_c;
            kh_reg      <= kh_c;
            kw_reg      <= kw_c;
            num_row_reg <= num_row[NUM_W-1:0];
            num_col_reg <= num_col[NUM_W-1:0];
            hw_reg      <= ADDR_WIDTH'(hw_c);
        end
        if (cmd.load_rows)
        begin
            rows_total_reg <= div_quo + NUM_W'(1);
        end
        if (cmd.load_cols)
        begin
            cols_total_reg <= div_quo + NUM_W'(1);
        end
    end

    // output size division, shared by both axes
    iag_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_col ? num_col_reg : num_row_reg),
        .divisor  (cmd.div_col ? sh : sv),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign status.cfg_hit  = cfg_hit;
    assign status.div_done = div_done;

    // walk counters with incrementally tracked input coordinates
    logic [CH_W-1:0]       chan_pos_reg, chan_pos_next;
    logic [KW-1:0]         tap_row_reg, tap_row_next;
    logic [KW-1:0]         tap_col_reg, tap_col_next;
    logic [NUM_W-1:0]      out_row_reg, out_row_next;
    logic [NUM_W-1:0]      out_col_reg, out_col_next;
    logic [CI_W-1:0]       elem_cnt_reg, elem_cnt_next;
    logic [TOFF_W-1:0]     tr_off_reg, tr_off_next;
    logic [TOFF_W-1:0]     tc_off_reg, tc_off_next;
    logic [COORD_W-1:0]    h_in_reg, h_in_next;
    logic [COORD_W-1:0]    w_in_reg, w_in_next;
    logic [ADDR_WIDTH-1:0] chan_base_reg, chan_base_next;

    logic col_end, row_end, tc_end, tr_end, ch_end, last_now;
    logic adv, accept, step;

    assign col_end  = out_col_reg == cols_total_reg - NUM_W'(1);
    assign row_end  = out_row_reg == rows_total_reg - NUM_W'(1);
    assign tc_end   = tap_col_reg == kw_reg - KW'(1);
    assign tr_end   = tap_row_reg == kh_reg - KW'(1);
    assign ch_end   = chan_pos_reg == eff_c_reg - CH_W'(1);
    assign last_now = col_end && row_end && tc_end && tr_end && ch_end;
    assign step     = accept && !empty_reg;

    always_comb
    begin
        chan_pos_next  = chan_pos_reg;
        tap_row_next   = tap_row_reg;
        tap_col_next   = tap_col_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        elem_cnt_next  = elem_cnt_reg;
        tr_off_next    = tr_off_reg;
        tc_off_next    = tc_off_reg;
        h_in_next      = h_in_reg;
        w_in_next      = w_in_reg;
        chan_base_next = chan_base_reg;
        if (cmd.prep || (step && last_now))
        begin
            chan_pos_next  = '0;
            tap_row_next   = '0;
            tap_col_next   = '0;
            out_row_next   = '0;
            out_col_next   = '0;
            elem_cnt_next  = '0;
            tr_off_next    = '0;
            tc_off_next    = '0;
            h_in_next      = '0 - COORD_W'(pv);
            w_in_next      = '0 - COORD_W'(ph);
            chan_base_next = '0;
        end
        else if (step)
        begin
            elem_cnt_next = elem_cnt_reg + CI_W'(1);
            if (!col_end)
            begin
                out_col_next = out_col_reg + NUM_W'(1);
                w_in_next    = w_in_reg + COORD_W'(sh);
            end
            else
            begin
                out_col_next = '0;
                if (!row_end)
                begin
                    out_row_next = out_row_reg + NUM_W'(1);
                    h_in_next    = h_in_reg + COORD_W'(sv);
                end
                else
                begin
                    out_row_next = '0;
                    if (!tc_end)
                    begin
                        tap_col_next = tap_col_reg + KW'(1);
                        tc_off_next  = tc_off_reg + TOFF_W'(dh);
                    end
                    else
                    begin
                        tap_col_next = '0;
                        tc_off_next  = '0;
                        if (!tr_end)
                        begin
                            tap_row_next = tap_row_reg + KW'(1);
                            tr_off_next  = tr_off_reg + TOFF_W'(dv);
                        end
                        else
                        begin
                            tap_row_next   = '0;
                            tr_off_next    = '0;
                            chan_pos_next  = chan_pos_reg + CH_W'(1);
                            chan_base_next = chan_base_reg + hw_reg;
                        end
                    end
                    h_in_next = COORD_W'(tr_off_next) - COORD_W'(pv);
                end
                w_in_next = COORD_W'(tc_off_next) - COORD_W'(ph);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_pos_reg  <= '0;
            tap_row_reg   <= '0;
            tap_col_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            elem_cnt_reg  <= '0;
            tr_off_reg    <= '0;
            tc_off_reg    <= '0;
            h_in_reg      <= '0;
            w_in_reg      <= '0;
            chan_base_reg <= '0;
        end
        else
        begin
            chan_pos_reg  <= chan_pos_next;
            tap_row_reg   <= tap_row_next;
            tap_col_reg   <= tap_col_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            elem_cnt_reg  <= elem_cnt_next;
            tr_off_reg    <= tr_off_next;
            tc_off_reg    <= tc_off_next;
            h_in_reg      <= h_in_next;
            w_in_reg      <= w_in_next;
            chan_base_reg <= chan_base_next;
        end
    end

    // padding test and row product, captured on transfer
    logic              h_neg, w_neg, h_over, w_over, is_pad;
    logic [PROD_W-1:0] row_prod;

    assign h_neg    = h_in_reg[COORD_W-1];
    assign w_neg    = w_in_reg[COORD_W-1];
    assign h_over   = !h_neg && (h_in_reg >= COORD_W'(eff_h_reg));
    assign w_over   = !w_neg && (w_in_reg >= COORD_W'(eff_w_reg));
    assign is_pad   = h_neg || w_neg || h_over || w_over;
    assign row_prod = PROD_W'(h_in_reg[DIM_W-1:0]) * PROD_W'(eff_w_reg);

    logic                  s1_valid_reg, s1_valid_next;
    logic [ADDR_WIDTH-1:0] s1_base_reg, s1_part_reg, s1_prod_reg;
    logic                  s1_pad_reg, s1_last_reg, s1_empty_reg;
    logic [CI_W-1:0]       s1_elem_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_WIDTH-1:0] out_addr_reg, out_addr_next;
    logic [CI_W-1:0]       out_idx_reg;
    logic                  out_pad_reg, out_last_reg, out_status_reg;

    assign adv           = !out_valid_reg || m_tready;
    assign s_tready      = cmd.run && (adv || !s1_valid_reg);
    assign accept        = s_tvalid && s_tready;
    assign s1_valid_next = (adv || !s1_valid_reg) ? accept : s1_valid_reg;
    assign out_valid_next = adv ? s1_valid_reg : out_valid_reg;
    assign out_addr_next = (s1_pad_reg || s1_empty_reg) ? '0
                         : s1_base_reg + s1_part_reg + s1_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_base_reg  <= s_tdata[ADDR_WIDTH-1:0];
            s1_part_reg  <= chan_base_reg + ADDR_WIDTH'(w_in_reg[DIM_W-1:0]);
            s1_prod_reg  <= ADDR_WIDTH'(row_prod);
            s1_pad_reg   <= !empty_reg && is_pad;
            s1_last_reg  <= !empty_reg && last_now;
            s1_empty_reg <= empty_reg;
            s1_elem_reg  <= empty_reg ? '0 : elem_cnt_reg;
        end
        if (adv && s1_valid_reg)
        begin
            out_addr_reg   <= out_addr_next;
            out_idx_reg    <= s1_elem_reg;
            out_pad_reg    <= s1_pad_reg;
            out_last_reg   <= s1_last_reg;
            out_status_reg <= s1_empty_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_idx_reg, out_addr_reg});
    assign m_tuser  = {out_status_reg, out_pad_reg};
    assign m_tlast  = out_last_reg;

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg |->
            out_addr_reg == '0 && out_idx_reg == '0 && !out_pad_reg && !out_last_reg)
        else $error("empty-geometry result carries nonzero fields");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run && !empty_reg |->
            out_col_reg < cols_total_reg && out_row_reg < rows_total_reg)
        else $error("output position counter beyond derived size");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_now |=> elem_cnt_reg == '0 && chan_pos_reg == '0)
        else $error("walk did not restart after final element");

    a_run_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.run) |-> elem_cnt_reg == '0 && out_col_reg == '0)
        else $error("walk not at origin when streaming starts");

endmodule

`default_nettype wire

// ===== hw/rtl/im2col_address_generator_top.sv =====
// results pass the capture stage, then the output register; one item per cycle sustained while m_tready is high
// the single capture stage takes one more input transfer while a result waits in the output register
// after reset and after each register write the output sizes are derived by a shared
// one-bit-per-cycle divider, rows then columns; input is not ready until both are done
// rst_n is asynchronous active low; registers return to reset values, walk restarts at zero
`default_nettype none

module im2col_address_generator_top #(
    parameter int MAX_CHANNELS = iag_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_DIM      = iag_pkg::MAX_DIM_DEF,
    parameter int MAX_KERNEL   = iag_pkg::MAX_KERNEL_DEF,
    parameter int ADDR_WIDTH   = iag_pkg::ADDR_WIDTH_DEF,
    localparam int IN_DATA_W   = ((ADDR_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((ADDR_WIDTH + iag_pkg::COL_IDX_W + 7) / 8) * 8
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire  [iag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [iag_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [IN_DATA_W-1:0]            s_tdata,   // batch_base
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [OUT_DATA_W-1:0]           m_tdata,   // image_address, column_index
    output logic [1:0]                      m_tuser,   // is_padding, status
    output logic                            m_tlast
);

    iag_pkg::iag_cmd_t    cmd;
    iag_pkg::iag_status_t status;

    iag_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    iag_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_DIM      (MAX_DIM),
        .MAX_KERNEL   (MAX_KERNEL),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
